// ===== hw/rtl/orl_pkg.sv =====
package orl_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned REC_W     = 32 + 8 + 3 * 64;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_LIST   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // datapath commands from the controller
    typedef struct packed {
        logic load;      // capture request
        logic clr_idx;   // index to zero
        logic inc_idx;   // index up by one
        logic dec_idx;   // index down by one
        logic idx_to_cnt;// index to the tail
        logic rd;        // read entry at index
        logic wr_prev;   // write read data to index+1 (shift up)
        logic wr_next;   // write read data to index-1 (shift down)
        logic wr_new;    // write new record at index
        logic cnt_clr;
        logic cnt_inc;
        logic cnt_dec;
        logic pos_cap;   // capture match position
        logic out_load;  // load result register
        logic out_rec;   // result carries the read record
        logic out_last;
        t_status out_st;
    } t_ctl;

    // datapath status to the controller
    typedef struct packed {
        logic       full;
        logic       empty;
        logic       idx_end;   // index == count
        logic       idx_last;  // index + 1 == count
        logic       idx_ge_pos;
        logic       idx_gt_pos;
        logic       hit;       // read data id equals key
        logic       out_busy;
        t_cmd       cmd;
    } t_sts;

endpackage

// ===== hw/rtl/orl_ram.sv =====
module orl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/orl_datapath.sv =====
module orl_datapath
    import orl_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    output t_sts         o_sts,
    input  logic [266:0] i_req,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [234:0] o_data,
    output logic [6:0]   o_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [2:0]       r_cmd;
    logic [31:0]      r_key;
    logic [REC_W-1:0] r_new;
    logic [CW-1:0]    r_cnt;
    logic [CW:0]      r_idx;
    logic [CW-1:0]    r_pos;
    logic [REC_W-1:0] rdata;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [REC_W-1:0] wdata;
    logic [CW:0]      wpos;
    logic             r_valid;
    logic [1:0]       r_st;
    logic [REC_W-1:0] r_rec;
    logic             r_last;
    logic [6:0]       r_ocnt;

    // record memory: id, age, three name words
    orl_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    // pick write address and data
    always_comb begin
        wpos  = r_idx;
        wdata = rdata;
        if (i_ctl.wr_prev) begin
            wpos = r_idx + 1'b1;
        end else if (i_ctl.wr_next) begin
            wpos = r_idx - 1'b1;
        end else if (i_ctl.wr_new) begin
            wdata = r_new;
        end
        we    = i_ctl.wr_prev | i_ctl.wr_next | i_ctl.wr_new;
        waddr = wpos[AW-1:0];
    end

    // hold request and index
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_req[2:0];
            r_key <= i_req[34:3];
            r_new <= i_req[266:35];
        end
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            if (i_ctl.clr_idx) begin
                r_idx <= '0;
            end else if (i_ctl.idx_to_cnt) begin
                r_idx <= {1'b0, r_cnt};
            end else if (i_ctl.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_ctl.dec_idx) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_ctl.pos_cap) begin
                r_pos <= r_idx[CW-1:0];
            end
            if (i_ctl.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_ctl.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_ctl.cnt_dec) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_ctl.out_load) begin
            r_st   <= i_ctl.out_st;
            r_rec  <= i_ctl.out_rec ? rdata : '0;
            r_last <= i_ctl.out_last;
            r_ocnt <= 7'(r_cnt);
        end
    end

    assign o_sts.full       = (r_cnt == CW'(DEPTH));
    assign o_sts.empty      = (r_cnt == '0);
    assign o_sts.idx_end    = (r_idx == {1'b0, r_cnt});
    assign o_sts.idx_last   = (r_idx + 1'b1 == {1'b0, r_cnt});
    assign o_sts.idx_ge_pos = (r_idx >= {1'b0, r_pos});
    assign o_sts.idx_gt_pos = (r_idx > {1'b0, r_pos});
    assign o_sts.hit        = (rdata[31:0] == r_key);
    assign o_sts.out_busy   = r_valid & ~i_ready;
    assign o_sts.cmd        = t_cmd'(r_cmd);

    assign o_valid = r_valid;
    assign o_data  = {r_last, r_rec, r_st};
    assign o_count = r_ocnt;

endmodule

// ===== hw/rtl/orl_ctrl.sv =====
module orl_ctrl
    import orl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DISP   = 10'b0000000010,
        S_SRD    = 10'b0000000100,
        S_SCHK   = 10'b0000001000,
        S_SHUP   = 10'b0000010000,
        S_SHDN   = 10'b0000100000,
        S_LRD    = 10'b0001000000,
        S_LOUT   = 10'b0010000000,
        S_DONE   = 10'b0100000000,
        S_SHRD   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_found, n_found;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
            r_st    <= n_st;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // sequence one request
    always_comb begin
        n_state = r_state;
        n_found = r_found;
        n_st    = r_st;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    o_ctl.clr_idx = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_st = ST_OK;
                n_found = 1'b0;
                case (i_sts.cmd)
                    CMD_CLEAR: begin
                        o_ctl.cnt_clr = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_APPEND: begin
                        if (i_sts.full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_ctl.idx_to_cnt = 1'b1;
                            o_ctl.pos_cap = 1'b0;
                        end
                        n_state = i_sts.full ? S_DONE : S_SCHK;
                        n_found = 1'b1;
                    end
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            n_st = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    CMD_DELETE: begin
                        n_state = S_SRD;
                    end
                    CMD_LIST: begin
                        if (i_sts.empty) begin
                            n_st = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_LRD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // search: index is read address, data arrives next cycle
            S_SRD: begin
                if (i_sts.idx_end) begin
                    n_state = S_SCHK;
                end else begin
                    o_ctl.rd = 1'b1;
                    n_state = S_SCHK;
                    n_found = 1'b1;
                end
            end
            S_SCHK: begin
                if (r_found && !i_sts.idx_end && !i_sts.hit &&
                    i_sts.cmd != CMD_APPEND) begin
                    o_ctl.inc_idx = 1'b1;
                    n_found = 1'b0;
                    n_state = S_SRD;
                end else begin
                    // index now holds the position (or count if no match)
                    o_ctl.pos_cap = 1'b1;
                    if (i_sts.cmd == CMD_DELETE) begin
                        if (i_sts.idx_end) begin
                            n_st = ST_NOT_FOUND;
                            n_state = S_DONE;
                        end else begin
                            o_ctl.inc_idx = 1'b1;
                            n_state = S_SHDN;
                        end
                    end else begin
                        o_ctl.idx_to_cnt = 1'b1;
                        n_state = S_SHUP;
                    end
                    n_found = 1'b0;
                end
            end
            // step down from the tail towards position, then place
            S_SHUP: begin
                if (i_sts.idx_gt_pos) begin
                    o_ctl.dec_idx = 1'b1;
                    n_found = 1'b0;
                    n_state = S_SHRD;
                end else begin
                    o_ctl.wr_new = 1'b1;
                    o_ctl.cnt_inc = 1'b1;
                    n_state = S_DONE;
                end
            end
            // wait for the entry at index, then move it to index+1
            S_SHRD: begin
                if (!r_found) begin
                    n_found = 1'b1;
                end else begin
                    o_ctl.wr_prev = 1'b1;
                    n_found = 1'b0;
                    n_state = S_SHUP;
                end
            end
            // move entries down from position+1 to the tail
            S_SHDN: begin
                if (!r_found) begin
                    if (i_sts.idx_end) begin
                        o_ctl.cnt_dec = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_found = 1'b1;
                    end
                end else begin
                    o_ctl.wr_next = 1'b1;
                    o_ctl.inc_idx = 1'b1;
                    n_found = 1'b0;
                end
            end
            S_LRD: begin
                if (!i_sts.out_busy) begin
                    n_state = S_LOUT;
                end
            end
            S_LOUT: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_rec = 1'b1;
                    o_ctl.out_st = ST_OK;
                    o_ctl.out_last = i_sts.idx_last;
                    o_ctl.inc_idx = 1'b1;
                    n_state = i_sts.idx_last ? S_IDLE : S_LRD;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_st = r_st;
                    o_ctl.out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.wr_prev, o_ctl.wr_next, o_ctl.wr_new}))
        else $error("two writes");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> !i_sts.out_busy) else $error("result overrun");
`endif

endmodule

// ===== hw/rtl/ordered_record_list.sv =====
// One request at a time: insert and delete search, then shift through the
// record memory; list reads the entries out in order; a stalled result
// holds the sequence.
// Reset: synchronous, active low; empties the list; memory is not cleared.
module ordered_record_list
    import orl_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd, key, rec_id, rec_age, name_lo, name_mid, name_hi, 5 zero bits
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, out_id, out_age, out_name_lo, out_name_mid, out_name_hi,
    // entry_count, 7 zero bits
    output logic [247:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    t_ctl         ctl;
    t_sts         sts;
    logic [234:0] data;
    logic [6:0]   count;

    orl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    orl_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_req   (s_axis_tdata[266:0]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (data),
        .o_count (count)
    );

    assign m_axis_tdata = {7'd0, count, data[233:0]};
    assign m_axis_tlast = data[234];

endmodule

// ===== dv/ordered_record_list_checker.sv =====
module ordered_record_list_checker
    import orl_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [271:0] i_req_data,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  logic [247:0] i_rsp_data,
    input  logic         i_rsp_last,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  age;
        logic [63:0] name_lo;
        logic [63:0] name_mid;
        logic [63:0] name_hi;
    } t_record;

    typedef struct packed {
        t_status     status;
        t_record     rec;
        logic        last;
        logic [6:0]  count;
    } t_reply;

    t_record list_mem [DEPTH];
    int unsigned list_len;
    t_reply expected_replies [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
        o_errors++;
    endtask

    function automatic t_reply make_reply(input t_status st, input t_record r,
                                          input logic last);
        t_reply p;
        p.status = st;
        p.rec    = r;
        p.last   = last;
        p.count  = list_len[6:0];
        return p;
    endfunction

    // apply one request to the model list and queue its replies
    task automatic apply_request(input logic [271:0] d);
        logic [2:0]  cmd;
        logic [31:0] key;
        t_record     r;
        t_record     none;
        int unsigned pos;
        cmd        = d[2:0];
        key        = d[34:3];
        r.id       = d[66:35];
        r.age      = d[74:67];
        r.name_lo  = d[138:75];
        r.name_mid = d[202:139];
        r.name_hi  = d[266:203];
        none       = '0;
        pos        = list_len;
        if (cmd == CMD_INSERT || cmd == CMD_DELETE) begin
            for (int i = list_len - 1; i >= 0; i--)
                if (list_mem[i].id == key) pos = i;
        end
        case (cmd)
            CMD_CLEAR: begin
                list_len = 0;
                expected_replies.push_back(make_reply(ST_OK, none, 1'b1));
            end
            CMD_APPEND, CMD_INSERT: begin
                if (list_len >= DEPTH) begin
                    expected_replies.push_back(make_reply(ST_FULL, none, 1'b1));
                end else begin
                    if (cmd == CMD_APPEND) pos = list_len;
                    for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = r;
                    list_len++;
                    expected_replies.push_back(make_reply(ST_OK, none, 1'b1));
                end
            end
            CMD_DELETE: begin
                if (pos >= list_len) begin
                    expected_replies.push_back(make_reply(ST_NOT_FOUND, none, 1'b1));
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                    expected_replies.push_back(make_reply(ST_OK, none, 1'b1));
                end
            end
            CMD_LIST: begin
                if (list_len == 0)
                    expected_replies.push_back(make_reply(ST_EMPTY, none, 1'b1));
                for (int i = 0; i < list_len; i++)
                    expected_replies.push_back(make_reply(ST_OK, list_mem[i],
                                                          i + 1 == list_len));
            end
            default: ;  // unused codes: drop silently
        endcase
    endtask

    // compare one reply with the oldest expectation
    task automatic check_reply(input logic [247:0] d, input logic last);
        t_reply w;
        if (expected_replies.size() == 0) begin
            $display("unexpected reply at %0t: %h", $realtime, d);
            o_errors++;
            return;
        end
        w = expected_replies.pop_front();
        if (d[1:0] != w.status)        report_mismatch("status", d[1:0], w.status);
        if (d[33:2] != w.rec.id)       report_mismatch("id", d[33:2], w.rec.id);
        if (d[41:34] != w.rec.age)     report_mismatch("age", d[41:34], w.rec.age);
        if (d[105:42] != w.rec.name_lo)  report_mismatch("name_lo", d[105:42], w.rec.name_lo);
        if (d[169:106] != w.rec.name_mid)
            report_mismatch("name_mid", d[169:106], w.rec.name_mid);
        if (d[233:170] != w.rec.name_hi) report_mismatch("name_hi", d[233:170], w.rec.name_hi);
        if (d[240:234] != w.count)     report_mismatch("count", d[240:234], w.count);
        if (last !== w.last)           report_mismatch("last", last, w.last);
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        list_len  = 0;
    end

    // watch both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_replies.delete();
        end else begin
            if (i_req_valid && i_req_ready) apply_request(i_req_data);
            if (i_rsp_valid && i_rsp_ready) begin
                check_reply(i_rsp_data, i_rsp_last);
                o_results++;
            end
        end
        o_pending = expected_replies.size();
    end

    initial o_pending = 0;

    final begin
        if (expected_replies.size() != 0)
            $display("%0d replies never arrived", expected_replies.size());
    end

endmodule

// ===== dv/ordered_record_list_tb.sv =====
module ordered_record_list_tb;
    import orl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = DEPTH_DEF;
    localparam int          CYCLE_CAP  = 200000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [271:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [247:0] m_data;
    logic         m_last;
    int           errors, pending, results;
    int           cycles = 0;
    int           commands = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;
    logic [31:0]  id_pool [8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_record_list #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .m_axis_tlast(m_last)
    );

    ordered_record_list_checker #(.DEPTH(DEPTH)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data),
        .i_rsp_valid(m_valid), .i_rsp_ready(m_ready), .i_rsp_data(m_data),
        .i_rsp_last(m_last),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // hold off the reply channel in short bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // guard against a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("** ordered_record_list: FAILED **");
            $finish;
        end
    end

    // issue one request, with an optional idle burst before it
    task automatic send_request(input t_cmd cmd, input logic [31:0] key,
                                input logic [31:0] id, input logic [7:0] age,
                                input logic [63:0] lo, input logic [63:0] mid,
                                input logic [63:0] hi);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {5'b0, hi, mid, lo, age, id, key, cmd};
        do @(posedge i_clk); while (!s_ready);
        commands++;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_id();
        return ($urandom_range(0, 5) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
    endfunction

    task automatic send_record(input t_cmd cmd, input logic [31:0] key,
                               input logic [31:0] id);
        send_request(cmd, key, id, 8'($urandom_range(0, 255)), rand_word(), rand_word(),
                     rand_word());
    endtask

    initial begin
        t_cmd cmd;
        int   pick;
        foreach (id_pool[i]) id_pool[i] = $urandom;
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7fff_ffff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list cases, then inserts, an append, a list and deletes
        send_request(CMD_LIST, '0, '0, '0, '0, '0, '0);
        send_request(CMD_DELETE, 32'h1234, '0, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h5555, 32'h8000_0000, 8'hff, '1, '1, '1);
        send_request(CMD_APPEND, '0, 32'h7fff_ffff, 8'h00, '0, '0, '0);
        send_request(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 8'h5a, '1, '0, '1);
        send_request(CMD_LIST, '0, '0, '0, '0, '0, '0);
        send_request(CMD_DELETE, 32'h8000_0000, '0, '0, '0, '0, '0);
        send_request(CMD_DELETE, 32'h8000_0000, '0, '0, '0, '0, '0);
        // ignored codes give no reply
        send_request(t_cmd'(3'd5), '1, '1, '1, '1, '1, '1);
        send_request(t_cmd'(3'd6), '0, '0, '0, '0, '0, '0);
        send_request(t_cmd'(3'd7), '1, '0, '1, '0, '1, '0);
        // fill to capacity, overflow, list it all, then clear and list the empty list
        for (int i = 0; i < DEPTH; i++) send_record(CMD_APPEND, '0, pick_id());
        send_record(CMD_APPEND, '0, pick_id());
        send_record(CMD_INSERT, id_pool[0], pick_id());
        send_request(CMD_LIST, '0, '0, '0, '0, '0, '0);
        send_request(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
        send_request(CMD_LIST, '0, '0, '0, '0, '0, '0);

        // random: mostly building and editing, with a list now and then
        for (int n = 0; n < 70; n++) begin
            if (n == 55) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 3)       cmd = CMD_CLEAR;
            else if (pick < 35) cmd = CMD_APPEND;
            else if (pick < 60) cmd = CMD_INSERT;
            else if (pick < 82) cmd = CMD_DELETE;
            else if (pick < 97) cmd = CMD_LIST;
            else                cmd = t_cmd'(3'($urandom_range(5, 7)));
            send_record(cmd, pick_id(), pick_id());
        end
        s_valid <= 1'b0;

        // drain, then allow for trailing activity
        while (pending != 0) @(posedge i_clk);
        repeat (3 * DEPTH + 8) @(posedge i_clk);

        $display("ran %0d commands, checked %0d replies, %0d mismatches",
                 commands, results, errors);
        if (errors == 0 && pending == 0) begin
            $display("** ordered_record_list: PASSED **");
        end else begin
            $display("** ordered_record_list: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/orl_pkg.sv
hw/rtl/orl_ram.sv
hw/rtl/orl_datapath.sv
hw/rtl/orl_ctrl.sv
hw/rtl/ordered_record_list.sv
dv/ordered_record_list_checker.sv
dv/ordered_record_list_tb.sv
